@@ rtl/seit_pkg.sv @@
// Package for the salience evicting item table: sizes, function codes,
// register indexes, request/result payloads and controller/datapath links.
// No dependencies.
package seit_pkg;

    localparam int CAPACITY = 8;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // function codes
    localparam logic [2:0] FN_ADD    = 3'd0;
    localparam logic [2:0] FN_REMOVE = 3'd1;
    localparam logic [2:0] FN_LOOKUP = 3'd2;
    localparam logic [2:0] FN_DECAY  = 3'd3;
    localparam logic [2:0] FN_CLEAR  = 3'd4;

    // register indexes (paddr[2])
    localparam logic REG_THRESH   = 1'b0;
    localparam logic REG_DECAY_EN = 1'b1;

    localparam logic [15:0] THRESH_RESET = 16'd19661;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] item_id;
        logic [15:0] item_salience;
        logic [15:0] decay_mult;
    } t_req;

    typedef struct packed {
        logic        ok;
        logic [2:0]  slot;
        logic        evicted;
        logic [31:0] evicted_id;
        logic [15:0] salience_out;
        logic [3:0]  live_count;
        logic [3:0]  dropped_count;
        logic [31:0] added_total;
        logic [31:0] evicted_total;
    } t_resp;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic look;
        logic dmul;
        logic dwr;
        logic apply;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic decay_run;
        logic last;
    } t_dp_stat;

endpackage

@@ rtl/seit_ctrl.sv @@
// Controller state machine of the salience evicting item table.
// Depends on seit_pkg.
module seit_ctrl import seit_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    output logic     o_done,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_DMUL,
        S_DWR,
        S_APPLY
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_state <= S_LOOK;
                        r_busy  <= 1'b1;
                    end
                end
                S_LOOK: begin
                    r_state <= i_stat.decay_run ? S_DMUL : S_APPLY;
                end
                S_DMUL: begin
                    r_state <= S_DWR;
                end
                S_DWR: begin
                    r_state <= i_stat.last ? S_APPLY : S_DMUL;
                end
                S_APPLY: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                    r_done  <= 1'b1;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy   = r_busy;
    assign o_done = r_done;

    assign o_cmd.load  = start && !r_busy;
    assign o_cmd.look  = (r_state == S_LOOK);
    assign o_cmd.dmul  = (r_state == S_DMUL);
    assign o_cmd.dwr   = (r_state == S_DWR);
    assign o_cmd.apply = (r_state == S_APPLY);

`ifndef ASSERT_OFF
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted request");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("done strobe longer than one cycle");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(busy) && !busy))
        else $error("done strobe without a finished request");
`endif

endmodule

@@ rtl/seit_dpath.sv @@
// Datapath of the salience evicting item table: entry registers, id/free/min
// search, shared decay multiplier, counters and result registers. Uses seit_pkg.
module seit_dpath import seit_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_stat    o_stat,
    input  t_req        i_req,
    input  logic [15:0] i_thresh,
    input  logic        i_decay_en,
    output t_resp       o_resp
);

    // latched request
    logic [2:0]  r_func;
    logic [31:0] r_id;
    logic [15:0] r_sal;
    logic [15:0] r_factor;

    // table
    logic [CAPACITY-1:0] r_valid;
    logic [31:0]         r_eid  [CAPACITY];
    logic [15:0]         r_esal [CAPACITY];

    // search results
    logic             r_hit, r_free;
    logic [IDX_W-1:0] r_hit_idx, r_free_idx, r_min_idx;
    logic             n_hit, n_free;
    logic [IDX_W-1:0] n_hit_idx, n_free_idx, n_min_idx;
    logic [16:0]      best;

    // decay sequencer
    logic [IDX_W-1:0] r_didx;
    logic [31:0]      r_prod;
    logic [3:0]       r_drop;
    logic             last;

    // counters and results
    logic [31:0] r_add_cnt, r_evict_cnt;
    logic        r_ok, r_evicted;
    logic [2:0]  r_slot;
    logic [31:0] r_ev_id;
    logic [15:0] r_sal_out;
    logic [3:0]  r_drop_out;

    logic             admit;
    logic             use_evict;
    logic [IDX_W-1:0] w_idx;
    logic [CNT_W-1:0] n_active;

    // id match and first free: lowest slot wins
    always_comb begin
        n_hit      = 1'b0;
        n_hit_idx  = '0;
        n_free     = 1'b0;
        n_free_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (r_valid[i] && r_eid[i] == r_id) begin
                n_hit     = 1'b1;
                n_hit_idx = IDX_W'(i);
            end
            if (!r_valid[i]) begin
                n_free     = 1'b1;
                n_free_idx = IDX_W'(i);
            end
        end
    end

    // lowest salience, first on ties
    always_comb begin
        best      = 17'h10000;
        n_min_idx = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (r_valid[i] && {1'b0, r_esal[i]} < best) begin
                best      = {1'b0, r_esal[i]};
                n_min_idx = IDX_W'(i);
            end
        end
    end

    assign admit     = (r_sal >= i_thresh);
    assign use_evict = !r_hit && !r_free;
    assign w_idx     = r_hit ? r_hit_idx : (r_free ? r_free_idx : r_min_idx);
    assign last      = (r_didx == IDX_W'(CAPACITY - 1));

    assign o_stat.decay_run = (r_func == FN_DECAY) && i_decay_en;
    assign o_stat.last      = last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func   <= i_req.func;
            r_id     <= i_req.item_id;
            r_sal    <= i_req.item_salience;
            r_factor <= i_req.decay_mult;
        end
        if (i_cmd.look) begin
            r_hit      <= n_hit;
            r_hit_idx  <= n_hit_idx;
            r_free     <= n_free;
            r_free_idx <= n_free_idx;
            r_min_idx  <= n_min_idx;
        end
        if (i_cmd.dmul) begin
            r_prod <= 32'(r_esal[r_didx]) * 32'(r_factor);
        end
    end

    // entry payload: written by add and by decay
    always_ff @(posedge i_clk) begin
        if (i_cmd.apply && r_func == FN_ADD && admit) begin
            r_eid[w_idx]  <= r_id;
            r_esal[w_idx] <= r_sal;
        end else if (i_cmd.dwr && r_valid[r_didx]) begin
            r_esal[r_didx] <= r_prod[31:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_add_cnt   <= '0;
            r_evict_cnt <= '0;
            r_didx      <= '0;
            r_drop      <= '0;
        end else begin
            if (i_cmd.load) begin
                r_didx <= '0;
                r_drop <= '0;
            end
            if (i_cmd.dwr) begin
                r_didx <= last ? '0 : r_didx + IDX_W'(1);
                if (r_valid[r_didx] && r_prod[31:16] < i_thresh) begin
                    r_valid[r_didx] <= 1'b0;
                    r_drop          <= r_drop + 4'd1;
                end
            end
            if (i_cmd.apply) begin
                unique case (r_func)
                    FN_ADD: begin
                        if (admit) begin
                            r_valid[w_idx] <= 1'b1;
                            r_add_cnt      <= r_add_cnt + 32'd1;
                            if (use_evict) begin
                                r_evict_cnt <= r_evict_cnt + 32'd1;
                            end
                        end
                    end
                    FN_REMOVE: begin
                        if (r_hit) begin
                            r_valid[r_hit_idx] <= 1'b0;
                        end
                    end
                    FN_CLEAR: begin
                        r_valid <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_ok       <= 1'b0;
            r_slot     <= '0;
            r_evicted  <= 1'b0;
            r_ev_id    <= '0;
            r_sal_out  <= '0;
            r_drop_out <= '0;
            unique case (r_func)
                FN_ADD: begin
                    if (admit) begin
                        r_ok      <= 1'b1;
                        r_slot    <= 3'(w_idx);
                        r_sal_out <= r_sal;
                        r_evicted <= use_evict;
                        r_ev_id   <= use_evict ? r_eid[r_min_idx] : 32'd0;
                    end
                end
                FN_REMOVE, FN_LOOKUP: begin
                    if (r_hit) begin
                        r_ok      <= 1'b1;
                        r_slot    <= 3'(r_hit_idx);
                        r_sal_out <= r_esal[r_hit_idx];
                    end
                end
                FN_DECAY: begin
                    r_ok       <= 1'b1;
                    r_drop_out <= i_decay_en ? r_drop : 4'd0;
                end
                FN_CLEAR: begin
                    r_ok <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_active = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            n_active = n_active + CNT_W'(r_valid[i]);
        end
    end

    assign o_resp.ok            = r_ok;
    assign o_resp.slot          = r_slot;
    assign o_resp.evicted       = r_evicted;
    assign o_resp.evicted_id    = r_ev_id;
    assign o_resp.salience_out  = r_sal_out;
    assign o_resp.live_count    = 4'(n_active);
    assign o_resp.dropped_count = r_drop_out;
    assign o_resp.added_total   = r_add_cnt;
    assign o_resp.evicted_total = r_evict_cnt;

`ifndef ASSERT_OFF
    a_evict_with_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_evict_cnt != $past(r_evict_cnt)) |-> (r_add_cnt == $past(r_add_cnt) + 32'd1))
        else $error("eviction counted without an add");
    a_lookup_keeps_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.apply && r_func == FN_LOOKUP) |=> $stable(r_valid))
        else $error("lookup changed valid bits");
    a_one_fill_per_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) <= $countones($past(r_valid)) + 1)
        else $error("more than one entry filled in a cycle");
`endif

endmodule

@@ rtl/salience_evicting_item_table.sv @@
// Top level of the salience evicting item table: APB-style register port and
// the controller/datapath pair. Depends on seit_pkg, seit_ctrl, seit_dpath.
//
// Usage
//   Request channel: drive i_req and raise start; the request is taken at the
//   rising edge where start is high and busy is low. busy stays high until the
//   request has finished its work; start is ignored while busy.
//   Result channel: o_done is high for exactly one cycle and o_result holds the
//   result in that cycle. The receiver cannot stall; the result is not held
//   beyond the strobe cycle in any guaranteed way.
//   Sequence: add, remove, lookup, clear, unknown codes and a disabled decay
//   tick go through a search state, then an update state; o_done comes in the
//   cycle after that, and busy is already low there, so a new request can be
//   taken in the strobe cycle.
//   An enabled decay tick walks the entries through one shared 16x16
//   multiplier, with a multiply and a write back/drop state per entry.
//   Configuration: admit_threshold at byte address 0, decay_enable at 4;
//   writes complete at psel & penable & pwrite (pready is tied high) and
//   must be made by the user only while the block is idle, which the block
//   does not enforce itself. Reads return the register value.
//   Reset (synchronous, active low) empties the table, zeroes both running
//   counters and restores the threshold to 19661 and decay enable to 1.
module salience_evicting_item_table import seit_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        start,
    output logic        busy,
    input  t_req        i_req,
    // result channel
    output logic        o_done,
    output t_resp       o_result,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] r_thresh;
    logic        r_decay_en;
    logic        cfg_wr;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // register index sits in paddr[2]; low address bits are don't-care
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh   <= THRESH_RESET;
            r_decay_en <= 1'b1;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_THRESH) begin
                r_thresh <= pwdata[15:0];
            end else begin
                r_decay_en <= pwdata[0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_DECAY_EN) ? {31'd0, r_decay_en} : {16'd0, r_thresh};

    seit_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .o_cmd   (dp_cmd),
        .i_stat  (dp_stat)
    );

    seit_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .o_stat     (dp_stat),
        .i_req      (i_req),
        .i_thresh   (r_thresh),
        .i_decay_en (r_decay_en),
        .o_resp     (o_result)
    );

endmodule

@@ tb/sv/seit_checker.sv @@
// Result checker for the salience evicting item table: predicts every accepted
// request from its own copy of the table and compares the results.
// Depends on seit_pkg.
module seit_checker import seit_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  t_req        i_req,
    input  logic        o_done,
    input  t_resp       o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // shadow table and registers
    logic        tab_valid [CAPACITY];
    logic [31:0] tab_id    [CAPACITY];
    logic [15:0] tab_sal   [CAPACITY];
    logic [31:0] adds_seen;
    logic [31:0] evicts_seen;
    logic [15:0] thresh;
    logic        decay_on;

    t_resp expected_results [$];
    int    mismatches = 0;

    function automatic int find_entry(logic [31:0] id);
        for (int i = 0; i < CAPACITY; i++) begin
            if (tab_valid[i] && tab_id[i] == id) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic t_resp predict_table_op(t_req r);
        t_resp       o;
        int          idx;
        int          n;
        logic [16:0] best;
        logic [31:0] prod;
        o   = '0;
        idx = -1;
        n   = 0;
        case (r.func)
            FN_ADD: begin
                if (r.item_salience >= thresh) begin
                    idx = find_entry(r.item_id);
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (idx < 0 && !tab_valid[i]) begin
                            idx = i;
                        end
                    end
                    if (idx < 0) begin
                        // table full: first slot holding the minimum goes
                        best = 17'h10000;
                        for (int i = 0; i < CAPACITY; i++) begin
                            if (tab_valid[i] && tab_sal[i] < best) begin
                                best = {1'b0, tab_sal[i]};
                                idx  = i;
                            end
                        end
                        o.evicted    = 1'b1;
                        o.evicted_id = tab_id[idx];
                        evicts_seen++;
                    end
                    tab_id[idx]    = r.item_id;
                    tab_sal[idx]   = r.item_salience;
                    tab_valid[idx] = 1'b1;
                    adds_seen++;
                    o.ok           = 1'b1;
                    o.slot         = 3'(idx);
                    o.salience_out = r.item_salience;
                end
            end
            FN_REMOVE, FN_LOOKUP: begin
                idx = find_entry(r.item_id);
                if (idx >= 0) begin
                    o.ok           = 1'b1;
                    o.slot         = 3'(idx);
                    o.salience_out = tab_sal[idx];
                    if (r.func == FN_REMOVE) begin
                        tab_valid[idx] = 1'b0;
                    end
                end
            end
            FN_DECAY: begin
                o.ok = 1'b1;
                if (decay_on) begin
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (tab_valid[i]) begin
                            prod       = 32'(tab_sal[i]) * 32'(r.decay_mult);
                            tab_sal[i] = prod[31:16];
                            if (prod[31:16] < thresh) begin
                                tab_valid[i] = 1'b0;
                                o.dropped_count++;
                            end
                        end
                    end
                end
            end
            FN_CLEAR: begin
                o.ok = 1'b1;
                for (int i = 0; i < CAPACITY; i++) begin
                    tab_valid[i] = 1'b0;
                end
            end
            default: ;
        endcase
        for (int i = 0; i < CAPACITY; i++) begin
            if (tab_valid[i]) begin
                n++;
            end
        end
        o.live_count    = 4'(n);
        o.added_total   = adds_seen;
        o.evicted_total = evicts_seen;
        return o;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_resp want;
        if (!i_rst_n) begin
            for (int i = 0; i < CAPACITY; i++) begin
                tab_valid[i] = 1'b0;
                tab_id[i]    = '0;
                tab_sal[i]   = '0;
            end
            adds_seen   = '0;
            evicts_seen = '0;
            thresh      = THRESH_RESET;
            decay_on    = 1'b1;
            expected_results.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[2])
                    REG_THRESH:   thresh   = pwdata[15:0];
                    REG_DECAY_EN: decay_on = pwdata[0];
                    default: ;
                endcase
            end
            // a result in the same cycle as a new request belongs to an older one
            if (o_done) begin
                if (expected_results.size() == 0) begin
                    $error("result strobe with no request outstanding");
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("ok",            32'(want.ok),            32'(o_result.ok));
                    check_field("slot",          32'(want.slot),          32'(o_result.slot));
                    check_field("evicted",       32'(want.evicted),       32'(o_result.evicted));
                    check_field("evicted_id",    want.evicted_id,         o_result.evicted_id);
                    check_field("salience_out",  32'(want.salience_out),
                                32'(o_result.salience_out));
                    check_field("live_count",    32'(want.live_count),
                                32'(o_result.live_count));
                    check_field("dropped_count", 32'(want.dropped_count),
                                32'(o_result.dropped_count));
                    check_field("added_total",   want.added_total,        o_result.added_total);
                    check_field("evicted_total", want.evicted_total,      o_result.evicted_total);
                end
            end
            if (start && !busy) begin
                expected_results.push_back(predict_table_op(i_req));
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_results.size();
    end

endmodule

@@ tb/sv/tb.sv @@
// Top of the salience evicting item table testbench: clock, reset, request
// and register stimulus, watchdog and verdict. Depends on seit_pkg,
// seit_checker and salience_evicting_item_table.
module tb import seit_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         PHASES         = 6;
    localparam int         PHASE_ITEMS    = 225;   // random requests per register setting
    localparam int         ID_POOL        = 12;    // more ids than slots, so evictions happen
    localparam int         SETTLE_CYCLES  = 4;
    localparam int         TAIL_CYCLES    = 40;    // longer than a full decay walk
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam logic [2:0] ADDR_THRESH    = {REG_THRESH, 2'b00};
    localparam logic [2:0] ADDR_DECAY_EN  = {REG_DECAY_EN, 2'b00};

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start   = 1'b0;
    logic        busy;
    t_req        i_req   = '0;
    logic        o_done;
    t_resp       o_result;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int idle_cycles = 0;

    // stimulus shaping state
    logic [15:0] cur_thresh = THRESH_RESET;
    logic        gaps_on    = 1'b1;
    logic [31:0] id_pool [ID_POOL];

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    salience_evicting_item_table dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_done   (o_done),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    seit_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req        (i_req),
        .o_done       (o_done),
        .o_result     (o_result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Watchdog: any request, result or register access counts as progress.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || (psel && penable && pready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    function automatic t_req mk(logic [2:0] f, logic [31:0] id, logic [15:0] s,
                                logic [15:0] d);
        t_req r;
        r.func          = f;
        r.item_id       = id;
        r.item_salience = s;
        r.decay_mult    = d;
        return r;
    endfunction

    // Salience biased around the current threshold: exactly at it, one below,
    // full scale, above it, or anything.
    function automatic logic [15:0] pick_salience();
        case ($urandom_range(5))
            0:       return cur_thresh;
            1:       return (cur_thresh == 16'd0) ? 16'd0 : cur_thresh - 16'd1;
            2:       return 16'hFFFF;
            3, 4:    return 16'($urandom_range(int'(cur_thresh), 65535));
            default: return 16'($urandom);
        endcase
    endfunction

    // Gentle factors half of the time so the table stays populated across ticks.
    function automatic logic [15:0] pick_factor();
        case ($urandom_range(5))
            0:       return 16'hFFFF;
            1:       return 16'h0000;
            2, 3:    return 16'($urandom_range(56000, 65535));
            default: return 16'($urandom);
        endcase
    endfunction

    // One random request: well-formed table traffic on a small id pool, with
    // unknown codes and fully random requests mixed in as noise. Unused fields
    // carry random junk so the block is shown to ignore them.
    function automatic t_req make_request();
        t_req r;
        int   pick;
        r.func          = 3'($urandom);
        r.item_id       = $urandom;
        r.item_salience = 16'($urandom);
        r.decay_mult    = 16'($urandom);
        pick = $urandom_range(99);
        if (pick < 45) begin
            r.func = FN_ADD;
        end else if (pick < 57) begin
            r.func = FN_REMOVE;
        end else if (pick < 77) begin
            r.func = FN_LOOKUP;
        end else if (pick < 87) begin
            r.func = FN_DECAY;
        end else if (pick < 90) begin
            r.func = FN_CLEAR;
        end else if (pick < 94) begin
            r.func = FN_CLEAR + 3'($urandom_range(1, 3));   // undefined codes
        end
        if (pick < 94) begin
            if ($urandom_range(99) < 85) begin
                r.item_id = id_pool[$urandom_range(ID_POOL - 1)];
            end
            r.item_salience = pick_salience();
            r.decay_mult    = pick_factor();
        end
        return r;
    endfunction

    // Present one request and return at the edge that takes it. The gap before
    // it is random, so start rises in every phase of the previous request.
    task automatic send_request(input t_req r);
        int          gap;
        logic [95:0] junk;
        gap = 0;
        if (gaps_on) begin
            if ($urandom_range(99) < 5) begin
                gap = $urandom_range(1, 25);
            end else begin
                while ($urandom_range(99) < 55) gap++;
            end
        end
        repeat (gap) begin
            junk  = {$urandom, $urandom, $urandom};
            start <= 1'b0;
            i_req <= junk[$bits(t_req)-1:0];
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
    endtask

    // Drop start and wait until every request has produced its result.
    task automatic settle();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Setup cycle and access cycle, then the port is released before returning.
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Directed requests under the reset register values.
    task automatic run_directed();
        // misses on an empty table
        send_request(mk(FN_LOOKUP, 32'h1234_5678, 16'h0, 16'h0));
        send_request(mk(FN_REMOVE, 32'h1234_5678, 16'h0, 16'h0));
        // one below the threshold is rejected, exactly at it is admitted
        send_request(mk(FN_ADD, 32'd100, THRESH_RESET - 16'd1, 16'h0));
        send_request(mk(FN_ADD, 32'd100, THRESH_RESET, 16'h0));
        send_request(mk(FN_ADD, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
        send_request(mk(FN_ADD, 32'd0, 16'd30000, 16'h0));
        // fill the rest; slot 4 ties slot 0 on the minimum salience
        send_request(mk(FN_ADD, 32'd3, 16'd40000, 16'h0));
        send_request(mk(FN_ADD, 32'd4, THRESH_RESET, 16'h0));
        send_request(mk(FN_ADD, 32'd5, 16'd50000, 16'h0));
        send_request(mk(FN_ADD, 32'd6, 16'd60000, 16'h0));
        send_request(mk(FN_ADD, 32'd7, 16'd45000, 16'h0));
        // full table: the tie goes to the lower slot
        send_request(mk(FN_ADD, 32'd8, 16'd20000, 16'h0));
        // existing id is overwritten in place, no eviction
        send_request(mk(FN_ADD, 32'd3, 16'd25000, 16'h0));
        send_request(mk(FN_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
        send_request(mk(FN_REMOVE, 32'd5, 16'h0, 16'h0));
        send_request(mk(FN_LOOKUP, 32'd5, 16'h0, 16'h0));
        send_request(mk(FN_ADD, 32'd9, 16'hFFFF, 16'h0));
        // decays: near-unity truncation, then a cut that drops some entries
        send_request(mk(FN_DECAY, 32'h0, 16'h0, 16'hFFFF));
        send_request(mk(FN_DECAY, 32'hFFFF_FFFF, 16'hFFFF, 16'd40000));
        // undefined codes do nothing
        send_request(mk(FN_CLEAR + 3'd1, 32'd9, 16'hFFFF, 16'hFFFF));
        send_request(mk(FN_CLEAR + 3'd3, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
        send_request(mk(FN_CLEAR, 32'd0, 16'h0, 16'h0));
        send_request(mk(FN_DECAY, 32'd0, 16'h0, 16'h0));
        send_request(mk(FN_ADD, 32'hA5A5_5A5A, 16'hFFFF, 16'h0));
        // zero factor drops everything
        send_request(mk(FN_DECAY, 32'd0, 16'h0, 16'h0));
    endtask

    initial begin
        logic [15:0] phase_thresh [PHASES];
        logic        phase_decay  [PHASES];
        int          ph;
        int          n;
        phase_thresh = '{16'd19661, 16'd1000, 16'd0, 16'hFFFF, 16'd0, 16'd40000};
        phase_decay  = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};
        phase_thresh[4] = 16'($urandom);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (id_pool[k]) id_pool[k] = $urandom;
        run_directed();

        for (ph = 0; ph < PHASES; ph++) begin
            // registers only change with the block idle; upper bits carry junk
            settle();
            write_reg(ADDR_THRESH, {16'($urandom), phase_thresh[ph]});
            write_reg(ADDR_DECAY_EN, {31'($urandom), phase_decay[ph]});
            cur_thresh = phase_thresh[ph];
            gaps_on    = (ph != 2);     // one setting runs back to back
            foreach (id_pool[k]) id_pool[k] = $urandom;
            id_pool[0] = '0;
            id_pool[1] = '1;
            if (!phase_decay[ph]) begin
                // decay disabled: an entry must come through a zero-factor tick untouched
                send_request(mk(FN_ADD, id_pool[2], 16'hFFFF, 16'h0));
                send_request(mk(FN_DECAY, id_pool[2], 16'h0, 16'h0));
                send_request(mk(FN_LOOKUP, id_pool[2], 16'h0, 16'h0));
            end
            for (n = 0; n < PHASE_ITEMS; n++) begin
                send_request(make_request());
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
